// File: rtl/positional_list_insert_delete_search_defines.svh
// ----------------------------------------------------------------------------
// Positional list assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_DELETE_SEARCH_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_SEARCH_DEFINES_SVH

// same-cycle implication
`define PLIST_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PLIST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/plist_pkg.sv
// ----------------------------------------------------------------------------
// Positional list package
// Operation and status codes, controller states and default sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package plist_pkg;

	// default number of list entries
	localparam int unsigned LIST_DEPTH = 16;

	// operation codes
	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_DELETE = 3'd1;
	localparam logic [2:0] OP_SEARCH = 3'd2;
	localparam logic [2:0] OP_READ   = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BADPOS   = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_USE
	} state_t;

endpackage

`default_nettype wire

// File: rtl/plist_req_if.sv
// ----------------------------------------------------------------------------
// Positional list request channel
// Valid/ready channel carrying one list operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface plist_req_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  op;
	logic        [4:0]  position;
	logic signed [31:0] value;

	modport source (output valid, output op, output position, output value, input ready);
	modport sink   (input valid, input op, input position, input value, output ready);
endinterface

`default_nettype wire

// File: rtl/plist_rsp_if.sv
// ----------------------------------------------------------------------------
// Positional list response channel
// Valid/ready channel carrying one operation result.
// ----------------------------------------------------------------------------
`default_nettype none

interface plist_rsp_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  status;
	logic        [4:0]  found_position;
	logic signed [31:0] read_value;
	logic        [4:0]  count;

	modport source (output valid, output status, output found_position,
		output read_value, output count, input ready);
	modport sink   (input valid, input status, input found_position,
		input read_value, input count, output ready);
endinterface

`default_nettype wire

// File: rtl/plist_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module plist_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// File: rtl/positional_list_insert_delete_search.sv
// ----------------------------------------------------------------------------
// Positional list: insert, delete, search, read, clear
// Ordered list of signed 32-bit values held in one RAM, with an entry count.
// ----------------------------------------------------------------------------
// Each request carries one operation and gets exactly one response. The list
// lives in a single RAM with one read and one write port and a registered
// read port; insert and delete move one entry at a time (read, then write
// back one place along), and search walks the entries one at a time too.
// Clear, unused codes and rejected requests finish at the accepting edge;
// insert shifts entries up from the last until position p is free, delete
// shifts the entries after p down, search stops at the first match or after
// the last entry. One request is in flight at a time; the result sits in an
// output register, so a new request is taken in the cycle the previous
// response is collected. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "positional_list_insert_delete_search_defines.svh"

module positional_list_insert_delete_search
	import plist_pkg::*;
#(
	parameter int unsigned DEPTH = LIST_DEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	plist_req_if.sink    req,
	plist_rsp_if.source  rsp
);

	localparam int unsigned AW   = $clog2(DEPTH);
	localparam int unsigned CW   = $clog2(DEPTH + 1);
	localparam int unsigned CMPW = ((CW > 5) ? CW : 5) + 1;

	// control state
	state_t        state_q, state_d;
	logic [2:0]    op_q;
	logic [AW-1:0] idx_q, idx_d;
	logic [AW-1:0] tgt_q, tgt_d;
	logic [AW-1:0] lim_q, lim_d;
	logic [CW-1:0] count_q, count_d;
	logic [31:0]   val_q;
	logic          out_valid_q;

	// result register
	logic [1:0]  status_q;
	logic [4:0]  found_q;
	logic [31:0] rdval_q;
	logic [4:0]  cnt_out_q;

	// memory port
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_wdata, ram_rdata;

	// result of the current cycle
	logic        finish;
	logic [1:0]  res_status;
	logic [4:0]  res_found;
	logic [31:0] res_rdval;

	logic acc;
	logic imm_done;

	// request decode
	logic [CMPW-1:0] pos_ext, cnt_ext, idx_p1, cnt_out_ext;
	logic            pos_zero, bad_ins, bad_del, full, ins_last, walk_last, hit;
	logic [AW-1:0]   pos_m1, cnt_m1;

	assign acc      = req.valid && req.ready;
	assign pos_ext  = CMPW'(req.position);
	assign cnt_ext  = CMPW'(count_q);
	assign pos_zero = (req.position == 5'd0);
	assign bad_ins  = pos_zero || (pos_ext > cnt_ext + CMPW'(1));
	assign bad_del  = pos_zero || (pos_ext > cnt_ext);
	assign full     = (count_q == CW'(DEPTH));
	assign pos_m1   = AW'(pos_ext - CMPW'(1));
	assign cnt_m1   = AW'(cnt_ext - CMPW'(1));
	assign idx_p1   = CMPW'(idx_q) + CMPW'(1);

	assign ins_last  = (idx_q == tgt_q);
	assign walk_last = (idx_q == lim_q);
	assign hit       = (ram_rdata == val_q);

	// requests that finish at the accepting edge
	always_comb begin
		case (req.op)
			OP_INSERT: imm_done = bad_ins || full;
			OP_DELETE: imm_done = bad_del;
			OP_SEARCH: imm_done = (count_q == '0);
			OP_READ:   imm_done = bad_del;
			default:   imm_done = 1'b1;
		endcase
	end

	assign req.ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc && !imm_done) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: begin
				if ((op_q == OP_INSERT && ins_last) || (op_q == OP_DELETE && walk_last)) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_USE;
				end
			end
			S_USE: begin
				case (op_q)
					OP_SEARCH: state_d = (hit || walk_last) ? S_IDLE : S_FETCH;
					OP_READ:   state_d = S_IDLE;
					default:   state_d = S_FETCH;
				endcase
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs, memory port and datapath updates
	always_comb begin
		finish     = 1'b0;
		res_status = ST_OK;
		res_found  = 5'd0;
		res_rdval  = 32'd0;
		ram_we     = 1'b0;
		ram_waddr  = idx_q;
		ram_wdata  = ram_rdata;
		ram_raddr  = idx_q;
		idx_d      = idx_q;
		tgt_d      = tgt_q;
		lim_d      = lim_q;
		count_d    = count_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (req.op)
						OP_INSERT: begin
							if (bad_ins) begin
								finish     = 1'b1;
								res_status = ST_BADPOS;
							end else if (full) begin
								finish     = 1'b1;
								res_status = ST_FULL;
							end else begin
								// walk down from the new last slot
								idx_d   = AW'(count_q);
								tgt_d   = pos_m1;
								count_d = count_q + CW'(1);
							end
						end
						OP_DELETE: begin
							if (bad_del) begin
								finish     = 1'b1;
								res_status = ST_BADPOS;
							end else begin
								idx_d   = pos_m1;
								lim_d   = cnt_m1;
								count_d = count_q - CW'(1);
							end
						end
						OP_SEARCH: begin
							if (count_q == '0) begin
								finish     = 1'b1;
								res_status = ST_NOTFOUND;
							end else begin
								idx_d = '0;
								lim_d = cnt_m1;
							end
						end
						OP_READ: begin
							if (bad_del) begin
								finish     = 1'b1;
								res_status = ST_BADPOS;
							end else begin
								idx_d = pos_m1;
							end
						end
						OP_CLEAR: begin
							finish  = 1'b1;
							count_d = '0;
						end
						default: begin
							finish = 1'b1;
						end
					endcase
				end
			end
			S_FETCH: begin
				case (op_q)
					OP_INSERT: begin
						if (ins_last) begin
							// gap is open, drop the new value in
							ram_we    = 1'b1;
							ram_wdata = val_q;
							finish    = 1'b1;
						end else begin
							ram_raddr = idx_q - AW'(1);
						end
					end
					OP_DELETE: begin
						if (walk_last) begin
							finish = 1'b1;
						end else begin
							ram_raddr = idx_q + AW'(1);
						end
					end
					default: begin
						ram_raddr = idx_q;
					end
				endcase
			end
			S_USE: begin
				case (op_q)
					OP_INSERT: begin
						// move entry one place up
						ram_we = 1'b1;
						idx_d  = idx_q - AW'(1);
					end
					OP_DELETE: begin
						// move entry one place down
						ram_we = 1'b1;
						idx_d  = idx_q + AW'(1);
					end
					OP_SEARCH: begin
						if (hit) begin
							finish    = 1'b1;
							res_found = idx_p1[4:0];
							res_rdval = ram_rdata;
						end else if (walk_last) begin
							finish     = 1'b1;
							res_status = ST_NOTFOUND;
						end else begin
							idx_d = idx_q + AW'(1);
						end
					end
					default: begin
						finish    = 1'b1;
						res_rdval = ram_rdata;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	assign cnt_out_ext = CMPW'(count_d);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working and result payload
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		tgt_q <= tgt_d;
		lim_q <= lim_d;
		if (acc) begin
			op_q  <= req.op;
			val_q <= req.value;
		end
		if (finish) begin
			status_q  <= res_status;
			found_q   <= res_found;
			rdval_q   <= res_rdval;
			cnt_out_q <= cnt_out_ext[4:0];
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = status_q;
	assign rsp.found_position = found_q;
	assign rsp.read_value     = $signed(rdval_q);
	assign rsp.count          = cnt_out_q;

	// list storage; a read that lands on the entry being written returns the
	// old word, and that read data is never used
	plist_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// checks
	`PLIST_ASSERT(a_count_range, 1'b1, count_q <= CW'(DEPTH), "entry count above depth")
	`PLIST_ASSERT(a_write_busy, ram_we, state_q != S_IDLE, "list write while idle")
	`PLIST_ASSERT_NEXT(a_count_hold, !acc, $stable(count_q), "count changed without request")
	`PLIST_ASSERT(a_rsp_origin, $rose(out_valid_q), $past(acc || state_q != S_IDLE),
		"response without request")

endmodule

`default_nettype wire
